>>> rtl/mss_pkg.sv
// Package for the Markov state sampler: widths, command and status codes.
// Used by mss_divider and markov_state_sampler; depends on nothing.
package mss_pkg;

    localparam int StateW    = 3;
    localparam int MaxStates = 1 << StateW;
    localparam int FracW     = 16;
    localparam int ProbW     = FracW + 1;
    localparam int RiskW     = 16;
    localparam int ScaledW   = ProbW + RiskW;
    localparam int BaseW     = ProbW + StateW;
    localparam int SumW      = ScaledW + StateW;
    localparam int NumW      = SumW + ProbW + StateW;
    localparam logic [ProbW-1:0] ProbOne = ProbW'(1) << FracW;

    localparam logic [2:0] CmdWrTable = 3'd0;
    localparam logic [2:0] CmdWrInit  = 3'd1;
    localparam logic [2:0] CmdWrRisk  = 3'd2;
    localparam logic [2:0] CmdNextRsk = 3'd3;
    localparam logic [2:0] CmdInitRsk = 3'd4;
    localparam logic [2:0] CmdNextBas = 3'd5;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StBadSt   = 2'd1;
    localparam logic [1:0] StNoRisk  = 2'd2;

endpackage

>>> rtl/mss_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on mss_pkg for operand widths.
module mss_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [mss_pkg::NumW-1:0]   i_num,
    input  logic [mss_pkg::SumW-1:0]   i_den,
    output logic                       o_done,
    output logic [mss_pkg::NumW-1:0]   o_quot
);
    localparam int CntW = $clog2(mss_pkg::NumW + 1);

    logic [mss_pkg::NumW-1:0] r_quot;
    logic [mss_pkg::SumW:0]   r_rem;
    logic [mss_pkg::SumW-1:0] r_den;
    logic [CntW-1:0]          r_cnt;
    logic                     r_busy;
    logic                     r_done;
    logic [mss_pkg::SumW:0]   n_trial;

    assign n_trial = {r_rem[mss_pkg::SumW-1:0], r_quot[mss_pkg::NumW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(mss_pkg::NumW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (n_trial >= {1'b0, r_den}) begin
                r_rem  <= n_trial - {1'b0, r_den};
                r_quot <= {r_quot[mss_pkg::NumW-2:0], 1'b1};
            end else begin
                r_rem  <= n_trial;
                r_quot <= {r_quot[mss_pkg::NumW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

>>> rtl/markov_state_sampler.sv
// Markov state sampler top level: tables, sequencer, multipliers and divider.
// Depends on mss_pkg and mss_divider.
//
// Each input word is handled on its own; the result of a write is registered
// through the S_OUT state. A sample with risks renormalizes its entries one
// by one, since every renormalized entry goes through the single bit-serial
// divider (56 steps). Sampling without risks skips the division pass.
// The input stalls until the result word has been taken.
module markov_state_sampler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [3:0]                    i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [2:0]                    i_command,
    input  logic [2:0]                    i_to_state,
    input  logic [2:0]                    i_from_state,
    input  logic [16:0]                   i_prob_value,
    input  logic [15:0]                   i_risk_value,
    input  logic                          i_risk_unset,
    input  logic [2:0]                    i_current_state,
    input  logic [16:0]                   i_random_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_sel_state,
    output logic [1:0]                    o_status
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCALE = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_DIVGO = 7'b0001000,
        S_DIVWT = 7'b0010000,
        S_DRAW  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    localparam int SW = mss_pkg::StateW;
    localparam int PW = mss_pkg::ProbW;

    logic [PW-1:0]               r_table [mss_pkg::MaxStates*mss_pkg::MaxStates];
    logic [PW-1:0]               r_init  [mss_pkg::MaxStates];
    logic [mss_pkg::RiskW-1:0]   r_risk  [mss_pkg::MaxStates];
    logic [mss_pkg::MaxStates-1:0] r_unset;
    logic [3:0]                  r_active;

    t_state                      r_st;
    logic [2:0]                  r_cmd;
    logic [SW-1:0]               r_cur;
    logic [PW-1:0]               r_rnd;
    logic [SW-1:0]               r_idx;
    logic [SW-1:0]               r_last;
    logic [mss_pkg::ScaledW-1:0] r_p [mss_pkg::MaxStates];
    logic [mss_pkg::BaseW-1:0]   r_base_tot;
    logic [mss_pkg::SumW-1:0]    r_scl_tot;
    logic [mss_pkg::SumW-1:0]    r_cum;
    logic                        r_ovalid;
    logic [SW-1:0]               r_onext;
    logic [1:0]                  r_ostat;
    logic [PW-1:0]               r_base_rd;
    logic [mss_pkg::RiskW-1:0]   r_risk_rd;

    logic [3:0]                  n_used;
    logic                        n_bad_state;
    logic [SW-1:0]               n_rd_idx;
    logic [SW-1:0]               n_rd_cur;
    logic                        n_rd_init;
    logic [mss_pkg::ScaledW-1:0] n_prod;
    logic [mss_pkg::SumW-1:0]    n_cum;
    logic [mss_pkg::ScaledW+mss_pkg::BaseW-1:0] n_numer;
    logic                        div_done;
    logic [mss_pkg::NumW-1:0]    div_quot;
    logic                        div_start;

    always_comb begin
        if (r_active == 4'd0) begin
            n_used = 4'd1;
        end else if (r_active > 4'(mss_pkg::MaxStates)) begin
            n_used = 4'(mss_pkg::MaxStates);
        end else begin
            n_used = r_active;
        end
    end

    assign n_bad_state = (4'(i_current_state) >= n_used);

    // Entries are fetched into registers ahead of use: entry 0 while idle, the next one
    // while scaling.
    always_comb begin
        if (r_st == S_IDLE) begin
            n_rd_idx  = '0;
            n_rd_cur  = i_current_state;
            n_rd_init = (i_command == mss_pkg::CmdInitRsk);
        end else begin
            n_rd_idx  = r_idx + 1'b1;
            n_rd_cur  = r_cur;
            n_rd_init = (r_cmd == mss_pkg::CmdInitRsk);
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rd_init) begin
            r_base_rd <= r_init[n_rd_idx];
        end else begin
            r_base_rd <= r_table[{n_rd_cur, n_rd_idx}];
        end
        r_risk_rd <= r_risk[n_rd_idx];
    end

    always_comb begin
        n_prod  = mss_pkg::ScaledW'(r_base_rd) * mss_pkg::ScaledW'(r_risk_rd);
        n_cum   = r_cum + mss_pkg::SumW'(r_p[r_idx]);
        n_numer = r_p[r_idx] * r_base_tot;
    end

    assign div_start = (r_st == S_DIVGO);

    mss_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mss_pkg::NumW'(n_numer)),
        .i_den   (r_scl_tot),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 4'd8;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
            r_unset  <= '1;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (i_valid && !r_ovalid) begin
                        r_cmd <= i_command;
                        r_cur <= i_current_state;
                        r_rnd <= (i_random_value > mss_pkg::ProbOne)
                                 ? mss_pkg::ProbOne : i_random_value;
                        r_idx <= '0;
                        r_last <= SW'(n_used - 4'd1);
                        r_base_tot <= '0;
                        r_scl_tot  <= '0;
                        r_cum   <= '0;
                        r_onext <= '0;
                        r_ostat <= ((i_command inside {mss_pkg::CmdNextRsk,
                                                       mss_pkg::CmdNextBas})
                                    && n_bad_state) ? mss_pkg::StBadSt : mss_pkg::StOk;
                        case (i_command)
                            mss_pkg::CmdWrTable: begin
                                r_table[{i_from_state, i_to_state}] <=
                                    (i_prob_value > mss_pkg::ProbOne)
                                    ? mss_pkg::ProbOne : i_prob_value;
                                r_st <= S_OUT;
                            end
                            mss_pkg::CmdWrInit: begin
                                r_init[i_to_state] <=
                                    (i_prob_value > mss_pkg::ProbOne)
                                    ? mss_pkg::ProbOne : i_prob_value;
                                r_st <= S_OUT;
                            end
                            mss_pkg::CmdWrRisk: begin
                                r_risk[i_to_state]  <= i_risk_value;
                                r_unset[i_to_state] <= i_risk_unset;
                                r_st <= S_OUT;
                            end
                            mss_pkg::CmdNextRsk, mss_pkg::CmdNextBas: begin
                                if (n_bad_state) begin
                                    r_st <= S_OUT;
                                end else begin
                                    r_st <= S_SCALE;
                                end
                            end
                            mss_pkg::CmdInitRsk: r_st <= S_SCALE;
                            default: r_st <= S_OUT;
                        endcase
                    end
                end
                S_SCALE: begin
                    // Load each entry; set entries are scaled by their risk unless the command is CmdNextBas.
                    if (r_cmd != mss_pkg::CmdNextBas && !r_unset[r_idx]) begin
                        r_p[r_idx] <= n_prod;
                        r_base_tot <= r_base_tot + mss_pkg::BaseW'(r_base_rd);
                        r_scl_tot  <= r_scl_tot + mss_pkg::SumW'(n_prod);
                    end else begin
                        r_p[r_idx] <= mss_pkg::ScaledW'(r_base_rd);
                    end
                    if (r_idx == r_last) begin
                        r_idx <= '0;
                        r_st  <= S_CHECK;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_CHECK: begin
                    if (r_scl_tot == '0) begin
                        if (r_base_tot != '0) begin
                            r_ostat <= mss_pkg::StNoRisk;
                            r_st    <= S_OUT;
                        end else begin
                            r_st <= S_DRAW;
                        end
                    end else if (!r_unset[r_idx]) begin
                        r_st <= S_DIVGO;
                    end else if (r_idx == r_last) begin
                        r_idx <= '0;
                        r_st  <= S_DRAW;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DIVGO: r_st <= S_DIVWT;
                S_DIVWT: begin
                    if (div_done) begin
                        r_p[r_idx] <= mss_pkg::ScaledW'(div_quot);
                        if (r_idx == r_last) begin
                            r_idx <= '0;
                            r_st  <= S_DRAW;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                            r_st  <= S_CHECK;
                        end
                    end
                end
                S_DRAW: begin
                    r_cum <= n_cum;
                    if (n_cum > mss_pkg::SumW'(r_rnd) || r_idx == r_last) begin
                        r_onext <= r_idx;
                        r_st    <= S_OUT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_st     <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_stall      = (r_st != S_IDLE) || r_ovalid;
    assign o_valid      = r_ovalid;
    assign o_sel_state  = r_onext;
    assign o_status     = r_ostat;
endmodule
